[rtl/rrtst_pkg.sv]
// shared constants for the round-robin task slot table
package rrtst_pkg;

    localparam int NUM_SLOTS_DEF = 16;

    localparam int MODE_W   = 2;
    localparam int SLOT_W   = 4;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 3;

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_KILL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SWITCH = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INIT   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FREE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE  = 3'd4;

    localparam logic [HANDLE_W-1:0] IDLE_ENTRY_RST = 32'd1;

endpackage

[rtl/rrtst_ram.sv]
// generic single write port ram with registered read
module rrtst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = rrtst_pkg::NUM_SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/round_robin_task_slot_table.sv]
// round-robin task slot table: add, kill, switch and init over a slot scan
//
//  channel   ports                                          transfer
//  command   i_start, o_busy, i_mode, i_slot_id,            i_start & !o_busy
//            i_entry_handle, i_arg_handle
//  result    o_done, o_status, o_slot, o_switched,          o_done
//            o_run_entry, o_run_arg
//  config    i_idle_entry_we, i_idle_entry                  i_idle_entry_we
//
//  add tests one slot per cycle from slot 0 until a free slot or the last slot
//  switch tests one slot per cycle round-robin over slots 1 to NUM_SLOTS-1
//  kill and init go straight to the result; o_done comes in the cycle after the transfer
//  o_busy is high from the transfer until the o_done cycle ends
//  reset and init clear the slot valid bits, so no clearing pass is needed
//  the receiver cannot stall; each result is held for one cycle only
module round_robin_task_slot_table #(
    parameter int NUM_SLOTS = rrtst_pkg::NUM_SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [rrtst_pkg::MODE_W-1:0]     i_mode,
    input  logic [rrtst_pkg::SLOT_W-1:0]     i_slot_id,
    input  logic [rrtst_pkg::HANDLE_W-1:0]   i_entry_handle,
    input  logic [rrtst_pkg::HANDLE_W-1:0]   i_arg_handle,
    input  logic                             i_idle_entry_we,
    input  logic [rrtst_pkg::HANDLE_W-1:0]   i_idle_entry,
    output logic                             o_done,
    output logic [rrtst_pkg::STATUS_W-1:0]   o_status,
    output logic [rrtst_pkg::SLOT_W-1:0]     o_slot,
    output logic                             o_switched,
    output logic [rrtst_pkg::HANDLE_W-1:0]   o_run_entry,
    output logic [rrtst_pkg::HANDLE_W-1:0]   o_run_arg
);

    localparam int IW = $clog2(NUM_SLOTS);
    localparam int CW = (IW > rrtst_pkg::SLOT_W) ? IW + 1 : rrtst_pkg::SLOT_W + 1;
    localparam int HW = rrtst_pkg::HANDLE_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);
    localparam logic [IW-1:0] SCAN_END = IW'(NUM_SLOTS - 2);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    logic [rrtst_pkg::MODE_W-1:0]    r_mode, n_mode;
    logic [HW-1:0]                   r_ent, n_ent;
    logic [HW-1:0]                   r_arg, n_arg;
    logic [IW-1:0]                   r_idx, n_idx;
    logic [IW-1:0]                   r_cnt, n_cnt;
    logic [IW-1:0]                   r_cur, n_cur;
    logic [IW-1:0]                   r_slot, n_slot;
    logic [NUM_SLOTS-1:0]            r_occ, n_occ;
    logic [NUM_SLOTS-1:0]            r_valid, n_valid;
    logic [HW-1:0]                   r_idle_entry, n_idle_entry;
    logic [HW-1:0]                   r_idle_snap, n_idle_snap;
    logic [rrtst_pkg::STATUS_W-1:0]  r_status, n_status;
    logic [rrtst_pkg::SLOT_W-1:0]    r_out_slot, n_out_slot;
    logic                            r_sw, n_sw;
    logic                            r_is_sw, n_is_sw;

    logic                            w_we;
    logic [IW-1:0]                   w_waddr;
    logic [2*HW-1:0]                 w_wdata;
    logic [2*HW-1:0]                 w_rdata;
    logic [IW-1:0]                   w_sid_idx;
    logic                            w_sid_range;
    logic [IW-1:0]                   w_found_slot;
    logic                            w_found;
    logic [HW-1:0]                   w_rd_entry;
    logic [HW-1:0]                   w_rd_arg;

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] j);
        logic [IW-1:0] res;
        if (j == '0 || j == LAST_IDX) begin
            res = IW'(1);
        end else begin
            res = j + IW'(1);
        end
        return res;
    endfunction

    assign w_sid_idx    = IW'(i_slot_id);
    assign w_sid_range  = CW'(i_slot_id) >= CW'(NUM_SLOTS);
    assign w_found      = r_occ[r_idx];
    assign w_found_slot = w_found ? r_idx : '0;

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_ent        = r_ent;
        n_arg        = r_arg;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_cur        = r_cur;
        n_slot       = r_slot;
        n_occ        = r_occ;
        n_valid      = r_valid;
        n_idle_entry = i_idle_entry_we ? i_idle_entry : r_idle_entry;
        n_idle_snap  = r_idle_snap;
        n_status     = r_status;
        n_out_slot   = r_out_slot;
        n_sw         = r_sw;
        n_is_sw      = r_is_sw;
        w_we         = 1'b0;
        w_waddr      = r_idx;
        w_wdata      = {r_ent, r_arg};

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_mode  = i_mode;
                    n_ent   = i_entry_handle;
                    n_arg   = i_arg_handle;
                    n_sw    = 1'b0;
                    n_is_sw = 1'b0;
                    case (i_mode)
                        rrtst_pkg::MODE_ADD: begin
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                        rrtst_pkg::MODE_SWITCH: begin
                            n_idx   = f_next(r_cur);
                            n_cnt   = '0;
                            n_state = S_SCAN;
                        end
                        rrtst_pkg::MODE_KILL: begin
                            n_out_slot = i_slot_id;
                            n_state    = S_RESP;
                            if (w_sid_range) begin
                                n_status = rrtst_pkg::ST_RANGE;
                            end else if (!r_occ[w_sid_idx]) begin
                                n_status = rrtst_pkg::ST_FREE;
                            end else begin
                                n_status             = rrtst_pkg::ST_OK;
                                w_we                 = 1'b1;
                                w_waddr              = w_sid_idx;
                                w_wdata              = '0;
                                n_valid[w_sid_idx]   = 1'b1;
                                n_occ[w_sid_idx]     = 1'b0;
                            end
                        end
                        default: begin
                            n_status    = rrtst_pkg::ST_OK;
                            n_out_slot  = '0;
                            n_valid     = '0;
                            n_occ       = '0;
                            n_occ[0]    = (r_idle_entry != '0);
                            n_idle_snap = r_idle_entry;
                            n_cur       = '0;
                            n_state     = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_mode == rrtst_pkg::MODE_ADD) begin
                    // lowest free slot
                    if (!r_occ[r_idx]) begin
                        w_we           = 1'b1;
                        n_valid[r_idx] = 1'b1;
                        n_occ[r_idx]   = (r_ent != '0);
                        n_status       = rrtst_pkg::ST_OK;
                        n_out_slot     = rrtst_pkg::SLOT_W'(r_idx);
                        n_state        = S_RESP;
                    end else if (r_idx == LAST_IDX) begin
                        n_status   = rrtst_pkg::ST_FULL;
                        n_out_slot = '0;
                        n_state    = S_RESP;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end else begin
                    // round-robin over slots 1 to NUM_SLOTS-1, idle slot 0 as fallback
                    if (w_found || r_cnt == SCAN_END) begin
                        n_status   = w_found ? rrtst_pkg::ST_OK : rrtst_pkg::ST_NONE;
                        n_sw       = (w_found_slot != r_cur);
                        n_cur      = w_found_slot;
                        n_slot     = w_found_slot;
                        n_out_slot = rrtst_pkg::SLOT_W'(w_found_slot);
                        n_is_sw    = 1'b1;
                        n_state    = S_RESP;
                    end else begin
                        n_idx = f_next(r_idx);
                        n_cnt = r_cnt + IW'(1);
                    end
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cur        <= '0;
            r_slot       <= '0;
            r_occ        <= NUM_SLOTS'(1);
            r_valid      <= '0;
            r_idle_entry <= rrtst_pkg::IDLE_ENTRY_RST;
            r_idle_snap  <= rrtst_pkg::IDLE_ENTRY_RST;
            r_sw         <= 1'b0;
            r_is_sw      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cur        <= n_cur;
            r_slot       <= n_slot;
            r_occ        <= n_occ;
            r_valid      <= n_valid;
            r_idle_entry <= n_idle_entry;
            r_idle_snap  <= n_idle_snap;
            r_sw         <= n_sw;
            r_is_sw      <= n_is_sw;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_ent      <= n_ent;
        r_arg      <= n_arg;
        r_idx      <= n_idx;
        r_cnt      <= n_cnt;
        r_status   <= n_status;
        r_out_slot <= n_out_slot;
    end

    // read port follows the next current slot, so read data matches r_slot
    rrtst_ram #(
        .WIDTH (2 * HW),
        .DEPTH (NUM_SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (n_slot),
        .o_rdata (w_rdata)
    );

    // slots never written since init read as their init contents
    always_comb begin
        if (r_valid[r_slot]) begin
            w_rd_entry = w_rdata[2*HW-1:HW];
            w_rd_arg   = w_rdata[HW-1:0];
        end else begin
            w_rd_entry = (r_slot == '0) ? r_idle_snap : '0;
            w_rd_arg   = '0;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = (r_state == S_RESP);
    assign o_status    = r_status;
    assign o_slot      = r_out_slot;
    assign o_switched  = r_is_sw & r_sw;
    assign o_run_entry = r_is_sw ? w_rd_entry : '0;
    assign o_run_arg   = r_is_sw ? w_rd_arg : '0;

endmodule

[verif/round_robin_task_slot_table_tb.sv]
// self-checking testbench for the round-robin task slot table
module round_robin_task_slot_table_tb;
    import rrtst_pkg::*;

    localparam int NUM_SLOTS = NUM_SLOTS_DEF;

    typedef struct {
        logic [MODE_W-1:0]   mode;
        logic [SLOT_W-1:0]   slot_id;
        logic [HANDLE_W-1:0] entry;
        logic [HANDLE_W-1:0] arg;
        int                  gap;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                switched;
        logic [HANDLE_W-1:0] run_entry;
        logic [HANDLE_W-1:0] run_arg;
    } outcome_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_start = 1'b0;
    logic [MODE_W-1:0]   i_mode = '0;
    logic [SLOT_W-1:0]   i_slot_id = '0;
    logic [HANDLE_W-1:0] i_entry_handle = '0;
    logic [HANDLE_W-1:0] i_arg_handle = '0;
    logic                i_idle_entry_we = 1'b0;
    logic [HANDLE_W-1:0] i_idle_entry = '0;
    logic                o_busy;
    logic                o_done;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_slot;
    logic                o_switched;
    logic [HANDLE_W-1:0] o_run_entry;
    logic [HANDLE_W-1:0] o_run_arg;

    // table model
    logic [NUM_SLOTS-1:0] live_map;
    logic [HANDLE_W-1:0]  entry_tab [NUM_SLOTS];
    logic [HANDLE_W-1:0]  arg_tab [NUM_SLOTS];
    logic [SLOT_W-1:0]    cur_slot;
    logic [HANDLE_W-1:0]  idle_cfg;

    cmd_t     cmd_q [$];
    outcome_t outcome_q [$];
    int       n_issued = 0;
    int       n_taken = 0;
    int       gap_cnt = 0;
    int       mismatches = 0;
    bit       calm = 1'b0;

    round_robin_task_slot_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_mode          (i_mode),
        .i_slot_id       (i_slot_id),
        .i_entry_handle  (i_entry_handle),
        .i_arg_handle    (i_arg_handle),
        .i_idle_entry_we (i_idle_entry_we),
        .i_idle_entry    (i_idle_entry),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_slot          (o_slot),
        .o_switched      (o_switched),
        .o_run_entry     (o_run_entry),
        .o_run_arg       (o_run_arg)
    );

    always #2 i_clk = ~i_clk;

    function automatic void clear_table();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            entry_tab[i] = '0;
            arg_tab[i] = '0;
        end
        entry_tab[0] = idle_cfg;
        live_map = '0;
        live_map[0] = (idle_cfg != '0);
        cur_slot = '0;
    endfunction

    function automatic outcome_t table_step(cmd_t c);
        outcome_t r;
        logic [SLOT_W-1:0] j;
        logic [SLOT_W-1:0] nxt;
        bit hit;
        r = '0;
        hit = 1'b0;
        nxt = '0;
        case (c.mode)
            MODE_ADD: begin
                r.status = ST_FULL;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!hit && !live_map[i]) begin
                        hit = 1'b1;
                        entry_tab[i] = c.entry;
                        arg_tab[i] = c.arg;
                        if (c.entry != '0)
                            live_map[i] = 1'b1;
                        r.status = ST_OK;
                        r.slot = SLOT_W'(i);
                    end
                end
            end
            MODE_KILL: begin
                r.slot = c.slot_id;
                if (int'(c.slot_id) >= NUM_SLOTS) begin
                    r.status = ST_RANGE;
                end else if (!live_map[c.slot_id]) begin
                    r.status = ST_FREE;
                end else begin
                    r.status = ST_OK;
                    entry_tab[c.slot_id] = '0;
                    arg_tab[c.slot_id] = '0;
                    live_map[c.slot_id] = 1'b0;
                end
            end
            MODE_SWITCH: begin
                j = cur_slot;
                for (int i = 0; i < NUM_SLOTS - 1; i++) begin
                    if (!hit) begin
                        j = SLOT_W'((j % (NUM_SLOTS - 1)) + 1);
                        if (live_map[j]) begin
                            hit = 1'b1;
                            nxt = j;
                        end
                    end
                end
                r.status = hit ? ST_OK : ST_NONE;
                if (nxt != cur_slot) begin
                    r.switched = 1'b1;
                    cur_slot = nxt;
                end
                r.slot = cur_slot;
                r.run_entry = entry_tab[cur_slot];
                r.run_arg = arg_tab[cur_slot];
            end
            default: begin
                clear_table();
                r.status = ST_OK;
            end
        endcase
        return r;
    endfunction

    // result check, then command transfer and config capture
    always @(posedge i_clk) begin
        cmd_t c;
        outcome_t e;
        if (!i_rst_n) begin
            idle_cfg = IDLE_ENTRY_RST;
            clear_table();
        end else begin
            if (o_done) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: result with none expected, status %0d slot %0d",
                             $time, o_status, o_slot);
                    mismatches++;
                end else begin
                    e = outcome_q.pop_front();
                    if (o_status !== e.status) begin
                        $display("%0t: status expected %0d got %0d", $time, e.status, o_status);
                        mismatches++;
                    end
                    if (o_slot !== e.slot) begin
                        $display("%0t: slot expected %0d got %0d", $time, e.slot, o_slot);
                        mismatches++;
                    end
                    if (o_switched !== e.switched) begin
                        $display("%0t: switched expected %0d got %0d", $time, e.switched,
                                 o_switched);
                        mismatches++;
                    end
                    if (o_run_entry !== e.run_entry) begin
                        $display("%0t: run_entry expected %h got %h", $time, e.run_entry,
                                 o_run_entry);
                        mismatches++;
                    end
                    if (o_run_arg !== e.run_arg) begin
                        $display("%0t: run_arg expected %h got %h", $time, e.run_arg, o_run_arg);
                        mismatches++;
                    end
                end
            end
            if (i_start && !o_busy) begin
                c.mode = i_mode;
                c.slot_id = i_slot_id;
                c.entry = i_entry_handle;
                c.arg = i_arg_handle;
                c.gap = 0;
                outcome_q.push_back(table_step(c));
                n_taken++;
            end
            if (i_idle_entry_we)
                idle_cfg = i_idle_entry;
        end
    end

    // command driver
    always @(negedge i_clk) begin
        cmd_t c;
        if (!i_rst_n) begin
            i_start <= 1'b0;
            gap_cnt <= 0;
        end else if (!i_start || n_taken == n_issued) begin
            if (cmd_q.size() == 0) begin
                i_start <= 1'b0;
            end else if (gap_cnt < cmd_q[0].gap) begin
                gap_cnt <= gap_cnt + 1;
                i_start <= 1'b0;
            end else begin
                c = cmd_q.pop_front();
                i_mode <= c.mode;
                i_slot_id <= c.slot_id;
                i_entry_handle <= c.entry;
                i_arg_handle <= c.arg;
                i_start <= 1'b1;
                n_issued <= n_issued + 1;
                gap_cnt <= 0;
            end
        end
    end

    function automatic logic [HANDLE_W-1:0] rand_handle();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_cmd(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] sid,
                            logic [HANDLE_W-1:0] ent, logic [HANDLE_W-1:0] arg);
        cmd_t c;
        c.mode = mode;
        c.slot_id = sid;
        c.entry = ent;
        c.arg = arg;
        c.gap = calm ? 0 : $urandom_range(0, 11);
        cmd_q.push_back(c);
    endtask

    task automatic push_rand(logic [MODE_W-1:0] mode);
        push_cmd(mode, SLOT_W'($urandom), rand_handle(), rand_handle());
    endtask

    task automatic fill_random(int n);
        int k;
        int sel;
        k = 0;
        while (k < n) begin
            sel = $urandom_range(0, 99);
            if (sel < 6) begin
                // fill the table past full
                for (int i = 0; i < NUM_SLOTS + 1; i++)
                    push_cmd(MODE_ADD, SLOT_W'($urandom), $urandom | 32'h1, rand_handle());
                k += NUM_SLOTS + 1;
            end else if (sel < 10) begin
                // empty the table
                for (int i = 0; i < NUM_SLOTS; i++)
                    push_cmd(MODE_KILL, SLOT_W'(i), rand_handle(), rand_handle());
                k += NUM_SLOTS;
            end else begin
                if (sel < 40)
                    push_rand(MODE_ADD);
                else if (sel < 65)
                    push_rand(MODE_KILL);
                else if (sel < 98)
                    push_rand(MODE_SWITCH);
                else
                    push_rand(MODE_INIT);
                k++;
            end
        end
    endtask

    task automatic drain();
        while (cmd_q.size() != 0 || i_start || outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_idle(logic [HANDLE_W-1:0] v);
        @(negedge i_clk);
        i_idle_entry_we <= 1'b1;
        i_idle_entry <= v;
        @(negedge i_clk);
        i_idle_entry_we <= 1'b0;
    endtask

    initial begin
        logic [HANDLE_W-1:0] cfg_vals [4];
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle fallback, zero entry, full table, kills of idle and current slot
        push_rand(MODE_SWITCH);
        push_cmd(MODE_ADD, 4'd0, '0, '1);
        push_cmd(MODE_ADD, 4'd15, '1, '0);
        for (int i = 2; i < NUM_SLOTS; i++)
            push_cmd(MODE_ADD, SLOT_W'($urandom), $urandom | 32'h1, $urandom);
        push_rand(MODE_ADD);
        push_rand(MODE_SWITCH);
        push_cmd(MODE_KILL, 4'd0, '0, '0);
        push_cmd(MODE_KILL, 4'd0, '1, '1);
        push_cmd(MODE_KILL, 4'd1, '0, '0);
        push_rand(MODE_SWITCH);
        push_cmd(MODE_KILL, 4'd15, '1, '1);
        push_rand(MODE_INIT);
        drain();

        cfg_vals[0] = '0;
        cfg_vals[1] = '1;
        cfg_vals[2] = $urandom;
        cfg_vals[3] = IDLE_ENTRY_RST;
        for (int p = 0; p < 4; p++) begin
            write_idle(cfg_vals[p]);
            calm = (p == 2);
            push_rand(MODE_INIT);
            push_rand(MODE_SWITCH);
            fill_random(400);
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

[round_robin_task_slot_table.f]
rtl/rrtst_pkg.sv
rtl/rrtst_ram.sv
rtl/round_robin_task_slot_table.sv
verif/round_robin_task_slot_table_tb.sv
